// ===== rtl/nssc_pkg.sv =====
// Package for the NACK sequence-set chunker.
// Holds request codes, controller states and the chunk record; no dependencies.
package nssc_pkg;

  localparam int SEQ_W = 16;
  localparam int REACH = 16;

  typedef enum logic [1:0] {
    REQ_ADD     = 2'd0,
    REQ_ADD_FCI = 2'd1,
    REQ_EMIT    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PAIR,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_EMIT_LAST
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] pid;
    logic [SEQ_W-1:0] blp;
    logic             valid;
    logic             last;
    logic             ovf;
  } chunk_t;

endpackage

// ===== rtl/nssc_out_reg.sv =====
// Output register for emitted chunks on the master-side stream.
// Depends on nssc_pkg for the chunk record.
module nssc_out_reg
  import nssc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  chunk_t       item,
  output logic         can_load,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // chunk_pid [15:0], chunk_blp [31:16]
  output logic [1:0]   m_tuser,   // chunk_valid [0], overflowed [1]
  output logic         m_tlast
);

  logic   valid;
  chunk_t held;

  assign can_load = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= item;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = {held.blp, held.pid};
  assign m_tuser  = {held.ovf, held.valid};
  assign m_tlast  = held.last;

endmodule

// ===== rtl/nack_sequence_set_chunker.sv =====
// Top level of the NACK sequence-set chunker: request decode, sorted-set memory
// and its controller. Depends on nssc_pkg and nssc_out_reg.
//
// Usage: requests arrive on the s_ stream, one transaction per request; the
// request code rides in s_tuser and the numbers in s_tdata. Only an emit
// request produces output: one m_ transaction per PID/BLP chunk, m_tlast on
// the final one, and a single chunk with chunk_valid low when the set is empty.
// Work per request, with n entries held and p the sorted position of a new number:
//   add number: search from the first entry up to p, then shift every entry
//     above p up to open a slot (a duplicate or a full set ends at the search);
//   add FCI: one such insert per number, plus a pass over each BLP bit;
//   emit: a walk over all n entries, held while the receiver stalls;
//   clear: complete in its accept cycle alone.
// The work is set by the walk through the entry memory, one read and one
// write per entry moved, with registered read data.
// A chunk waits in an output register, so the next request is taken while a
// result is still pending; when the register is full and m_tready is low the
// walk holds at the next chunk boundary until the receiver drains it.
// Reset empties the set and clears the overflow flag at once; the memory
// needs no clearing pass, since only the first count entries are ever read.
module nack_sequence_set_chunker
  import nssc_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // seq_num [15:0], fci_pid [31:16], fci_blp [47:32]
  input  logic [1:0]   s_tuser,   // req_type [1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // chunk_pid [15:0], chunk_blp [31:16]
  output logic [1:0]   m_tuser,   // chunk_valid [0], overflowed [1]
  output logic         m_tlast
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;

  logic [CW-1:0]    count, count_next;
  logic             ovf, ovf_next;
  logic [CW-1:0]    pos, pos_next;
  logic [AW-1:0]    sh, sh_next;
  logic [SEQ_W-1:0] val, val_next;
  logic             pair, pair_next;
  logic [4:0]       bit_idx, bit_idx_next;
  logic [SEQ_W-1:0] pair_pid, pair_pid_next;
  logic [SEQ_W-1:0] pair_blp, pair_blp_next;
  logic             first, first_next;
  logic [SEQ_W-1:0] cpid, cpid_next;
  logic [SEQ_W-1:0] cblp, cblp_next;
  logic             cvalid, cvalid_next;

  logic [SEQ_W-1:0] mem [CAPACITY];
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [SEQ_W-1:0] mem_wdata, rdata;

  logic   out_load, can_load;
  chunk_t out_item;

  logic       acc;
  req_t       req;
  logic       scan_end, full, sh_at_pos, far, after_pid;
  logic [SEQ_W-1:0] delta, delta_m1;

  assign s_tready  = (state == ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign req       = req_t'(s_tuser);
  assign scan_end  = (pos == count);
  assign full      = (count == CAP_C);
  assign sh_at_pos = (sh == pos[AW-1:0]);
  assign delta     = rdata - cpid;
  assign delta_m1  = delta - 16'd1;
  assign after_pid = (rdata > cpid);
  assign far       = (delta > 16'(REACH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (req)
            REQ_ADD, REQ_ADD_FCI: state_next = ST_SCAN_RD;
            REQ_EMIT:             state_next = (count == '0) ? ST_EMIT_LAST : ST_EMIT_RD;
            REQ_CLEAR:            state_next = ST_IDLE;
            default:              state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (!scan_end) begin
          state_next = ST_SCAN_CHK;
        end else if (full) begin
          state_next = pair ? ST_PAIR : ST_IDLE;
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SCAN_CHK: begin
        if (rdata < val) begin
          state_next = ST_SCAN_RD;
        end else if (rdata == val || full) begin
          state_next = pair ? ST_PAIR : ST_IDLE;
        end else begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (sh_at_pos) begin
          state_next = pair ? ST_PAIR : ST_IDLE;
        end else begin
          state_next = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_PAIR: begin
        if (bit_idx[4]) begin
          state_next = ST_IDLE;
        end else if (pair_blp[bit_idx[3:0]]) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD:  state_next = scan_end ? ST_EMIT_LAST : ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        if (first || !after_pid || !far || can_load) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_LAST: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next    = count;
    ovf_next      = ovf;
    pos_next      = pos;
    sh_next       = sh;
    val_next      = val;
    pair_next     = pair;
    bit_idx_next  = bit_idx;
    pair_pid_next = pair_pid;
    pair_blp_next = pair_blp;
    first_next    = first;
    cpid_next     = cpid;
    cblp_next     = cblp;
    cvalid_next   = cvalid;
    mem_we        = 1'b0;
    mem_waddr     = sh;
    mem_wdata     = val;
    mem_re        = 1'b0;
    mem_raddr     = pos[AW-1:0];
    out_load      = 1'b0;
    out_item      = '{pid: cpid, blp: cblp, valid: cvalid, last: 1'b0, ovf: ovf};
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          pos_next     = '0;
          first_next   = 1'b1;
          bit_idx_next = '0;
          unique case (req)
            REQ_ADD: begin
              val_next  = s_tdata[15:0];
              pair_next = 1'b0;
            end
            REQ_ADD_FCI: begin
              val_next      = s_tdata[31:16];
              pair_pid_next = s_tdata[31:16];
              pair_blp_next = s_tdata[47:32];
              pair_next     = 1'b1;
            end
            REQ_EMIT: begin
              cpid_next   = '0;
              cblp_next   = '0;
              cvalid_next = (count != '0);
            end
            REQ_CLEAR: begin
              count_next = '0;
              ovf_next   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (!scan_end) begin
          mem_re = 1'b1;
        end else if (full) begin
          ovf_next = 1'b1;
        end else begin
          sh_next = count[AW-1:0];
        end
      end
      ST_SCAN_CHK: begin
        if (rdata < val) begin
          pos_next = pos + 1'b1;
        end else if (rdata != val) begin
          if (full) begin
            ovf_next = 1'b1;
          end else begin
            sh_next = count[AW-1:0];
          end
        end
      end
      ST_SHIFT_RD: begin
        if (sh_at_pos) begin
          mem_we     = 1'b1;
          count_next = count + 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = sh - 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rdata;
        sh_next   = sh - 1'b1;
      end
      ST_PAIR: begin
        if (bit_idx[4]) begin
          pair_next = 1'b0;
        end else begin
          bit_idx_next = bit_idx + 1'b1;
          if (pair_blp[bit_idx[3:0]]) begin
            val_next = pair_pid + 16'(bit_idx) + 16'd1;
            pos_next = '0;
          end
        end
      end
      ST_EMIT_RD: begin
        if (!scan_end) begin
          mem_re = 1'b1;
        end
      end
      ST_EMIT_CHK: begin
        if (first) begin
          cpid_next  = rdata;
          cblp_next  = '0;
          first_next = 1'b0;
          pos_next   = pos + 1'b1;
        end else if (!after_pid) begin
          pos_next = pos + 1'b1;
        end else if (!far) begin
          cblp_next = cblp | (16'd1 << delta_m1[3:0]);
          pos_next  = pos + 1'b1;
        end else if (can_load) begin
          out_load  = 1'b1;
          cpid_next = rdata;
          cblp_next = '0;
          pos_next  = pos + 1'b1;
        end
      end
      ST_EMIT_LAST: begin
        out_item.last = 1'b1;
        out_load      = can_load;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      pair  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      pair  <= pair_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    sh       <= sh_next;
    val      <= val_next;
    bit_idx  <= bit_idx_next;
    pair_pid <= pair_pid_next;
    pair_blp <= pair_blp_next;
    first    <= first_next;
    cpid     <= cpid_next;
    cblp     <= cblp_next;
    cvalid   <= cvalid_next;
  end

  nssc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .item     (out_item),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count beyond capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (acc && req == REQ_CLEAR) |=> (count == '0 && !ovf))
    else $error("clear left entries or overflow flag");

  a_emit_keeps_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD || state == ST_EMIT_CHK || state == ST_EMIT_LAST)
      |=> ($stable(count) && $stable(ovf)))
    else $error("emit changed the set");

  a_ovf_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (!ovf && ovf_next) |-> full)
    else $error("overflow flagged with room left");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> can_load)
    else $error("chunk loaded over a pending result");
`endif

endmodule
